FILE: src/prime_sieve_table_macros.svh
// Assertion macros shared by the prime sieve table RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PRIME_SIEVE_TABLE_MACROS_SVH
`define PRIME_SIEVE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define PSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/psv_pkg.sv
// Shared types and constants for the prime sieve table.
// No dependencies; used by psv_seq and prime_sieve_table.
`timescale 1ns / 1ps

package psv_pkg;

  // Default table size (largest index held)
  localparam int MAX_LIMIT_DEF = 65535;

  // Fixed field widths
  localparam int LIMIT_W  = 16;
  localparam int IDX_W    = 16;
  localparam int STATUS_W = 2;
  // Sieve root i stays <= 256, so i*i and i*i + k*i fit in 17 bits
  localparam int ROOT_W   = 9;
  localparam int SQ_W     = 17;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Command codes
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

FILE: src/psv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module psv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/psv_seq.sv
// Build sequencer: fills the flag memory, then runs the sieve over it.
// Depends on psv_pkg and prime_sieve_table_macros.svh.
`timescale 1ns / 1ps
`include "prime_sieve_table_macros.svh"

module psv_seq #(
  parameter int MAX_LIMIT = psv_pkg::MAX_LIMIT_DEF,
  localparam int AW       = $clog2(MAX_LIMIT + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [psv_pkg::LIMIT_W-1:0] lim_in,
  output psv_pkg::seq_stat_t          stat,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic                        mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic                        mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_MARK = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [psv_pkg::LIMIT_W-1:0]   lim_r, lim_nxt;
  logic [psv_pkg::LIMIT_W-1:0]   cnt_r, cnt_nxt;
  logic [psv_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [psv_pkg::SQ_W-1:0]      sq_r, sq_nxt;
  logic [psv_pkg::SQ_W-1:0]      mul_r, mul_nxt;
  logic [psv_pkg::SQ_W-1:0]      lim_ext;
  logic                          done;

  assign lim_ext = {1'b0, lim_r};

  // Sequencer next state and memory requests
  always_comb begin
    state_nxt = state_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    root_nxt  = root_r;
    sq_nxt    = sq_r;
    mul_nxt   = mul_r;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_r);
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = AW'(root_r);
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          lim_nxt   = lim_in;
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end
      end
      // Mark 0..L prime, with 0 and 1 written as not prime
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = (cnt_r >= psv_pkg::LIMIT_W'(2));
        if (cnt_r == lim_r) begin
          root_nxt  = psv_pkg::ROOT_W'(2);
          sq_nxt    = psv_pkg::SQ_W'(4);
          state_nxt = S_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // Stop once i*i passes the limit, else fetch flag[i]
      S_RD: begin
        if (sq_r > lim_ext) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(root_r);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (mem_rdata) begin
          mul_nxt   = sq_r;
          state_nxt = S_MARK;
        end else begin
          root_nxt  = root_r + 1'b1;
          sq_nxt    = sq_r + psv_pkg::SQ_W'({root_r, 1'b1});
          state_nxt = S_RD;
        end
      end
      // Clear i*i, i*i+i, ... up to the limit
      S_MARK: begin
        if (mul_r <= lim_ext) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(mul_r);
          mem_wdata = 1'b0;
          mul_nxt   = mul_r + psv_pkg::SQ_W'(root_r);
        end else begin
          root_nxt  = root_r + 1'b1;
          sq_nxt    = sq_r + psv_pkg::SQ_W'({root_r, 1'b1});
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lim_r  <= lim_nxt;
    cnt_r  <= cnt_nxt;
    root_r <= root_nxt;
    sq_r   <= sq_nxt;
    mul_r  <= mul_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done;

  `PSV_ASSERT_NOW(a_go_when_idle, go, state_r == S_IDLE, "build started while sequencer busy")
  `PSV_ASSERT_NOW(a_rw_exclusive, mem_we, !mem_re, "sequencer reads and writes in one cycle")
  `PSV_ASSERT_NOW(a_mark_in_range, mem_we && state_r == S_MARK, mul_r <= lim_ext, "sieve write beyond limit")

endmodule

FILE: src/prime_sieve_table.sv
// Prime sieve table top level: command decode, query path, config register.
// Depends on psv_pkg, psv_ram, psv_seq and prime_sieve_table_macros.svh.
//
// Usage:
//   A request is taken when start is high and busy is low. in_command
//   selects a build (CMD_BUILD) or a query of in_query_index (CMD_QUERY).
//   Each request gives one result: out_valid is high for one cycle with
//   out_is_prime and out_status. The receiver cannot stall; results must
//   be taken in the cycle they appear.
//   Queries: result in the next cycle, one query per cycle while no build
//   runs; busy stays low. Status reports an index above the built limit
//   or a table not yet built, with out_is_prime low.
//   Build: busy rises the cycle after the request. The sequencer writes
//   all L+1 flags, then for each root i with i*i <= L reads flag[i] and,
//   for a prime root, clears its multiples from i*i up to L; build time
//   is bounded by the single memory write port.
//   L is the configured limit, clamped to MAX_LIMIT.
//   Configuration: cfg_data is written when cfg_valid and cfg_ready are
//   high; cfg_ready is low during a build.
//   Reset: the table reads as not built and the limit returns to 65535.
//   Flag memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "prime_sieve_table_macros.svh"

module prime_sieve_table #(
  parameter int MAX_LIMIT = psv_pkg::MAX_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [psv_pkg::IDX_W-1:0]     in_query_index,
  output logic                          out_valid,
  output logic                          out_is_prime,
  output logic [psv_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psv_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_LIMIT + 1);

  logic [psv_pkg::LIMIT_W-1:0] limit_r;
  logic [psv_pkg::LIMIT_W-1:0] built_r;
  logic                        tbl_valid_r;
  logic                        out_valid_r;
  logic                        q_ok_r;
  psv_pkg::status_t            status_r;
  psv_pkg::status_t            q_status;
  logic [psv_pkg::LIMIT_W-1:0] lim_eff;
  logic                        accept;
  logic                        build_go;
  logic                        query_go;
  psv_pkg::seq_stat_t          seq_stat;
  logic                        seq_we;
  logic [AW-1:0]               seq_waddr;
  logic                        seq_wdata;
  logic                        seq_re;
  logic [AW-1:0]               seq_raddr;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic                        ram_rdata;

  // Request decode
  assign busy     = seq_stat.busy;
  assign accept   = start && !seq_stat.busy;
  assign build_go = accept && (in_command == psv_pkg::CMD_BUILD);
  assign query_go = accept && (in_command == psv_pkg::CMD_QUERY);

  // Build limit, clamped to the table size
  assign lim_eff = (int'(limit_r) > MAX_LIMIT) ? psv_pkg::LIMIT_W'(MAX_LIMIT) : limit_r;

  // Query status from the table state at request time
  always_comb begin
    if (!tbl_valid_r) begin
      q_status = psv_pkg::ST_NOT_BUILT;
    end else if (in_query_index > built_r) begin
      q_status = psv_pkg::ST_RANGE;
    end else begin
      q_status = psv_pkg::ST_OK;
    end
  end

  // Config register and table state
  assign cfg_ready = !seq_stat.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= psv_pkg::LIMIT_RESET;
      built_r     <= '0;
      tbl_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (build_go) begin
        built_r     <= lim_eff;
        tbl_valid_r <= 1'b1;
      end
      out_valid_r <= query_go || seq_stat.done;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (query_go) begin
      status_r <= q_status;
      q_ok_r   <= (q_status == psv_pkg::ST_OK);
    end else if (seq_stat.done) begin
      status_r <= psv_pkg::ST_OK;
      q_ok_r   <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = q_ok_r && ram_rdata;
  assign out_status   = status_r;

  // Read port shared between sequencer and queries
  assign ram_re    = seq_re || query_go;
  assign ram_raddr = seq_re ? seq_raddr : AW'(in_query_index);

  psv_seq #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (build_go),
    .lim_in    (lim_eff),
    .stat      (seq_stat),
    .mem_we    (seq_we),
    .mem_waddr (seq_waddr),
    .mem_wdata (seq_wdata),
    .mem_re    (seq_re),
    .mem_raddr (seq_raddr),
    .mem_rdata (ram_rdata)
  );

  psv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LIMIT + 1)
  ) u_flags (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `PSV_ASSERT_NEXT(a_query_result, query_go, out_valid, "query gave no result next cycle")
  `PSV_ASSERT_NOW(a_prime_only_ok, out_valid && out_is_prime, out_status == psv_pkg::ST_OK, "flag set with error status")
  `PSV_ASSERT_NEXT(a_build_result, seq_stat.done, out_valid && !out_is_prime && out_status == psv_pkg::ST_OK, "bad build result")

endmodule
